@@ hw/rtl/ipg_pkg.sv @@
// ----------------------------------------------------------------------------
// ipg_pkg: shared types and constants of the PPS interval pulse generator
// Output indexes, timing constants and the precomputed request record that
// passes from the prep stage to the core stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ipg_pkg;

  // Output slots, in the order of the level vector
  localparam int unsigned NUM_OUT    = 5;
  localparam int unsigned IDX_HALF   = 0;
  localparam int unsigned IDX_ONE    = 1;
  localparam int unsigned IDX_SIX    = 2;
  localparam int unsigned IDX_THIRTY = 3;
  localparam int unsigned IDX_SIXTY  = 4;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned WIDTH_W = 12;

  // Pulse width in microseconds: 4095 ms * 1000 fits in 22 bits
  localparam int unsigned PW_US_W   = 22;
  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned PW_RESET_MS = 100;
  localparam logic [PW_US_W-1:0] PW_US_RESET = PW_US_W'(PW_RESET_MS * US_PER_MS);

  // Delay from the PPS edge to the mid-second pulse
  localparam logic [TIME_W-1:0] MID_DELAY_US = TIME_W'(500000);

  // Request after the prep stage: item-only terms already worked out
  typedef struct packed {
    logic [TIME_W-1:0]  now_us;
    logic [COUNT_W-1:0] pps_total;
    logic               mid_elapsed;  // edge valid and 500 ms gone by
    logic               div6;
    logic               div30;
    logic               div60;
    logic [TIME_W-1:0]  new_dl;       // now + width, mod 2^32
    logic               new_drop;     // a pulse raised now ends at once
  } prep_t;

  typedef logic [NUM_OUT-1:0] level_t;

endpackage : ipg_pkg

`default_nettype wire

@@ hw/rtl/ipg_prep.sv @@
// ----------------------------------------------------------------------------
// ipg_prep: input register stage
// Takes one request and registers it with its divisibility flags, the
// mid-second elapsed test and the off time a raise in this request would get.
// ----------------------------------------------------------------------------
`default_nettype none

module ipg_prep (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [ipg_pkg::TIME_W-1:0]         now_us,
  input  wire logic [ipg_pkg::COUNT_W-1:0]        pps_total,
  input  wire logic                               last_edge_valid,
  input  wire logic [ipg_pkg::TIME_W-1:0]         last_edge_us,
  input  wire logic [ipg_pkg::PW_US_W-1:0]        pw_us,
  output logic                                    prep_valid,
  input  wire logic                               prep_ready,
  output ipg_pkg::prep_t                          prep
);

  // Residue mod 15: 16 = 1 mod 15, so the nibble sum keeps the residue
  function automatic logic [3:0] mod15(input logic [31:0] v);
    logic [6:0] s;
    logic [4:0] f;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(v[4*i +: 4]);
    end
    f = 5'(s[6:4]) + 5'(s[3:0]);
    if (f >= 5'd15) begin
      f = f - 5'd15;
    end
    return f[3:0];
  endfunction

  logic                         valid_r;
  ipg_pkg::prep_t               prep_r;
  ipg_pkg::prep_t               prep_nxt;
  logic [3:0]                   r15;
  logic                         div3;
  logic [ipg_pkg::TIME_W-1:0]   elapsed;

  assign in_ready   = !valid_r || prep_ready;
  assign prep_valid = valid_r;
  assign prep       = prep_r;

  // Item-only terms
  always_comb begin
    r15     = mod15(pps_total);
    div3    = (r15 == 4'd0) || (r15 == 4'd3) || (r15 == 4'd6) ||
              (r15 == 4'd9) || (r15 == 4'd12);
    elapsed = now_us - last_edge_us;

    prep_nxt.now_us      = now_us;
    prep_nxt.pps_total   = pps_total;
    prep_nxt.mid_elapsed = last_edge_valid && (elapsed >= ipg_pkg::MID_DELAY_US);
    prep_nxt.div6        = !pps_total[0] && div3;
    prep_nxt.div30       = !pps_total[0] && (r15 == 4'd0);
    prep_nxt.div60       = (pps_total[1:0] == 2'b00) && (r15 == 4'd0);
    prep_nxt.new_dl      = now_us + ipg_pkg::TIME_W'(pw_us);
    prep_nxt.new_drop    = (prep_nxt.new_dl != '0) && (now_us >= prep_nxt.new_dl);
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prep_r <= prep_nxt;
    end
  end

endmodule : ipg_prep

`default_nettype wire

@@ hw/rtl/ipg_core.sv @@
// ----------------------------------------------------------------------------
// ipg_core: pulse state and result register
// Detects a PPS count change, raises and drops the five outputs against their
// off times and holds the output levels as the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipg_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             prep_valid,
  output logic                  prep_ready,
  input  wire ipg_pkg::prep_t   prep,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ipg_pkg::level_t       levels
);

  logic                         out_valid_r;
  logic [ipg_pkg::COUNT_W-1:0]  seen_r;
  logic                         mid_done_r;
  logic [ipg_pkg::TIME_W-1:0]   dl_r [ipg_pkg::NUM_OUT];
  ipg_pkg::level_t              lvl_r;

  logic [ipg_pkg::TIME_W-1:0]   dl_nxt [ipg_pkg::NUM_OUT];
  ipg_pkg::level_t              lvl_nxt;
  ipg_pkg::level_t              raise;
  logic                         chg;
  logic                         mid_fire;
  logic                         mid_done_nxt;
  logic                         drop;
  logic                         advance;

  assign prep_ready = !out_valid_r || out_ready;
  assign advance    = prep_valid && prep_ready;
  assign out_valid  = out_valid_r;
  assign levels     = lvl_r;

  // Raise requests for this item
  always_comb begin
    chg          = (prep.pps_total != seen_r);
    mid_fire     = (!mid_done_r || chg) && prep.mid_elapsed;
    mid_done_nxt = mid_fire || (mid_done_r && !chg);

    raise                      = '0;
    raise[ipg_pkg::IDX_HALF]   = chg || mid_fire;
    raise[ipg_pkg::IDX_ONE]    = chg;
    raise[ipg_pkg::IDX_SIX]    = chg && prep.div6;
    raise[ipg_pkg::IDX_THIRTY] = chg && prep.div30;
    raise[ipg_pkg::IDX_SIXTY]  = chg && prep.div60;
  end

  // Per output: raise, then off check
  always_comb begin
    for (int i = 0; i < ipg_pkg::NUM_OUT; i++) begin
      drop = 1'b0;
      if (raise[i]) begin
        dl_nxt[i]  = prep.new_dl;
        lvl_nxt[i] = 1'b1;
        drop       = prep.new_drop;
      end else begin
        dl_nxt[i]  = dl_r[i];
        lvl_nxt[i] = lvl_r[i];
        drop       = (dl_r[i] != '0) && (prep.now_us >= dl_r[i]);
      end
      if (drop) begin
        dl_nxt[i]  = '0;
        lvl_nxt[i] = 1'b0;
      end
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      mid_done_r  <= 1'b0;
      lvl_r       <= '0;
      for (int i = 0; i < ipg_pkg::NUM_OUT; i++) begin
        dl_r[i] <= '0;
      end
    end else begin
      if (prep_ready) begin
        out_valid_r <= prep_valid;
      end
      if (advance) begin
        seen_r     <= prep.pps_total;
        mid_done_r <= mid_done_nxt;
        lvl_r      <= lvl_nxt;
        for (int i = 0; i < ipg_pkg::NUM_OUT; i++) begin
          dl_r[i] <= dl_nxt[i];
        end
      end
    end
  end

endmodule : ipg_core

`default_nettype wire

@@ hw/rtl/pps_interval_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// pps_interval_pulse_generator: PPS-locked interval pulse outputs
// Per polling tick, raises the 0.5 s, 1 s, 6 s, 30 s and 60 s outputs from
// the PPS count and the last edge time and drops them after the pulse width.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   now_us, pps_total, last_edge_valid, last_edge_us
//   out      out_valid / out_ready pulse_half_sec .. pulse_sixty_sec
//   cfg      cfg_wr_en             pulse_len_ms (no wait, no read-back)
//
// One request per cycle while out_ready holds; a request passes the prep register, then the result register.
// The count/deadline state update closes within the core stage.
// Synchronous active-low reset clears state, levels and sets width to 100 ms.
// A stalled result holds the core; the prep stage still takes one request.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_interval_pulse_generator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ipg_pkg::TIME_W-1:0]   in_now_us,
  input  wire logic [ipg_pkg::COUNT_W-1:0]  in_pps_total,
  input  wire logic                         in_last_edge_valid,
  input  wire logic [ipg_pkg::TIME_W-1:0]   in_last_edge_us,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_pulse_half_sec,
  output logic                              out_pulse_one_sec,
  output logic                              out_pulse_six_sec,
  output logic                              out_pulse_thirty_sec,
  output logic                              out_pulse_sixty_sec,
  input  wire logic                         cfg_wr_en,
  input  wire logic [ipg_pkg::WIDTH_W-1:0]  cfg_pulse_len_ms
);

  logic [ipg_pkg::PW_US_W-1:0]  pw_us_r;
  logic [ipg_pkg::PW_US_W-1:0]  pw_us_nxt;
  logic                         prep_valid;
  logic                         prep_ready;
  ipg_pkg::prep_t               prep;
  ipg_pkg::level_t              levels;

  // Width register, kept in microseconds
  assign pw_us_nxt = ipg_pkg::PW_US_W'(cfg_pulse_len_ms) *
                     ipg_pkg::PW_US_W'(ipg_pkg::US_PER_MS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_us_r <= ipg_pkg::PW_US_RESET;
    end else if (cfg_wr_en) begin
      pw_us_r <= pw_us_nxt;
    end
  end

  ipg_prep u_prep (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .now_us          (in_now_us),
    .pps_total       (in_pps_total),
    .last_edge_valid (in_last_edge_valid),
    .last_edge_us    (in_last_edge_us),
    .pw_us           (pw_us_r),
    .prep_valid      (prep_valid),
    .prep_ready      (prep_ready),
    .prep            (prep)
  );

  ipg_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .prep_valid (prep_valid),
    .prep_ready (prep_ready),
    .prep       (prep),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .levels     (levels)
  );

  assign out_pulse_half_sec   = levels[ipg_pkg::IDX_HALF];
  assign out_pulse_one_sec    = levels[ipg_pkg::IDX_ONE];
  assign out_pulse_six_sec    = levels[ipg_pkg::IDX_SIX];
  assign out_pulse_thirty_sec = levels[ipg_pkg::IDX_THIRTY];
  assign out_pulse_sixty_sec  = levels[ipg_pkg::IDX_SIXTY];

  // An empty result slot never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result slot");

  // An accepted request lands in the prep stage
  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> prep_valid)
    else $error("accepted request lost before prep stage");

  // Levels move only when a request enters the result register
  a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(prep_valid && prep_ready) |=> $stable(levels))
    else $error("output levels changed without a request");

endmodule : pps_interval_pulse_generator

`default_nettype wire
